@@ rtl/pms_pkg.sv @@
// Shared types, constants and helpers for the pointer motion smoother.
`timescale 1ns / 1ps
package pms_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_W = 64;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  localparam logic [0:0] CMD_MOTION = 1'b0;
  localparam logic [0:0] CMD_FRAME  = 1'b1;

  localparam logic [1:0] REG_SMOOTH_EN = 2'd0;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = 32'h7fff_ffff;
    else if (v < -66'sd2147483648) sat32 = 32'h8000_0000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic [31:0] usat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    usat_add = s[32] ? 32'hffff_ffff : s[31:0];
  endfunction
endpackage

@@ rtl/pms_div.sv @@
// Shared unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pms_div import pms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output div_ctl_t         ctl,
  output logic [DIV_W-1:0] quo
);
  logic [DIV_W-1:0] q_r, q_nxt, rem_r, rem_nxt, den_r, den_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_W:0] sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r, q_r[DIV_W-1]};
    if (start) begin
      q_nxt = num; rem_nxt = '0; den_nxt = den; cnt_nxt = 7'(DIV_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = DIV_W'(sh - {1'b0, den_r});
        q_nxt = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DIV_W-1:0];
        q_nxt = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign ctl = '{start: start, busy: busy_r, done: done_r};
  assign quo = q_r;
endmodule

@@ rtl/pointer_motion_smoother.sv @@
// Top level of the two-axis pointer motion smoother.
`timescale 1ns / 1ps
// Pointer motion smoother. A motion item (command 0) folds rel_x/rel_y into
// per-frame accumulators and holds in_stall for one cycle, so a new motion
// item is not taken until the fold is done. Motion items produce no result. An
// end-of-frame item (command 1) runs each axis in turn through a small
// sequencer built around one shared 64-step restoring divider. Each division
// yields 64 quotient bits and then a done strobe. One shared 32x32 multiplier
// forms the rescale and spread products, and the final tenth as a reciprocal
// multiply. With smoothing off or on a long frame, an axis skips the divider.
// With smoothing on, an axis runs it for the seconds-per-sample estimate, again
// for a rescale or a spread, or twice more when the smoothed value is scaled
// down. A frame-end item holds in_stall until both axes and the output step
// are done and the result is handed to the output register.
// The result waits in an output register until taken. While an earlier result
// still waits, hold the sequence before the tenth of each axis, and hold the
// input too.
module pointer_motion_smoother import pms_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic signed [15:0] in_rel_x,
  input  logic signed [15:0] in_rel_y,
  input  logic [15:0] in_frame_delta,
  input  logic [15:0] in_frame_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_axis_x_out,
  output logic signed [31:0] out_axis_y_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [31:0] QUARTER = 32'(64'd1 << (FRAC_BITS - 2));
  localparam logic [31:0] STT_RST = 32'(((64'd1 << FRAC_BITS) + 64'd62) / 64'd125);
  // ceil(2^35 / 10): x * RECIP10 >> 35 equals x / 10 for any 32-bit x
  localparam logic [31:0] RECIP10 = 32'hcccc_cccd;

  typedef enum logic [3:0] {
    S_IDLE, S_MOT, S_AX, S_SPS, S_DEC, S_WAIT_V, S_WAIT_SC, S_WAIT_SM,
    S_TEN, S_NEXT, S_OUT
  } state_t;

  typedef enum logic [1:0] {D_V, D_SC, D_SM} dk_t;

  state_t state_r, state_nxt;
  logic en_r;
  logic signed [31:0] acc_r [2];
  logic [31:0] stt_r [2], cnt_r [2], zd_r [2];
  logic signed [31:0] sm_r [2];
  logic [15:0] lfs_r;
  logic signed [15:0] rel_r [2];
  logic [31:0] d_r, sps_r;
  logic [15:0] fn_r;
  logic ax_r;
  logic signed [31:0] v_r;
  logic vneg_r;
  logic [31:0] res_r [2];
  logic ov_r;

  logic div_start;
  logic [DIV_W-1:0] div_num, div_den, div_q;
  div_ctl_t dctl;

  pms_div u_div (.clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
                 .ctl(dctl), .quo(div_q));

  assign pready = 1'b1;
  assign prdata = {31'd0, en_r};
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_axis_x_out = res_r[0];
  assign out_axis_y_out = res_r[1];

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // Shared multiplier: |value| * frame time, or (|value| + 5) * 1/10 at the tenth.
  // A zero reading spreads the smoothed value instead of the reading.
  logic signed [31:0] sval;
  logic [31:0] smag, vmag, mul_a, mul_b, ten_q;
  logic [63:0] mul_p;
  logic [31:0] cur_cnt;
  logic [32:0] sps2;
  logic [32:0] zd_sum;
  always_comb begin
    sval = (v_r == 0) ? sm_r[ax_r] : v_r;
    smag = sval[31] ? 32'(-sval) : 32'(sval);
    vmag = v_r[31] ? 32'(-v_r) : 32'(v_r);
    if (state_r == S_TEN) begin
      mul_a = vmag + 32'd5;
      mul_b = RECIP10;
    end else begin
      mul_a = smag;
      mul_b = d_r;
    end
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    ten_q = 32'(mul_p >> 35);
    cur_cnt = (cnt_r[ax_r] == 32'd0) ? 32'd1 : cnt_r[ax_r];
    sps2 = {sps_r, 1'b0};
    zd_sum = {1'b0, usat_add(zd_r[ax_r], d_r)};
  end

  dk_t dk_r;
  logic signed [65:0] sq;

  always_comb begin
    div_start = 1'b0; div_num = '0; div_den = 64'd1;
    sq = vneg_r ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = in_command ? S_AX : S_MOT;
      S_MOT: state_nxt = S_IDLE;
      S_AX: begin
        if (!en_r || d_r >= QUARTER) state_nxt = S_TEN;
        else begin
          div_start = 1'b1; div_num = {32'd0, stt_r[ax_r]};
          div_den = {32'd0, cur_cnt}; state_nxt = S_SPS;
        end
      end
      S_SPS: if (dctl.done) state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = S_TEN;
        if (v_r == 0) begin
          if (zd_sum[31:0] < sps_r) begin
            div_start = 1'b1; div_num = mul_p; div_den = {32'd0, sps_r};
            state_nxt = S_WAIT_V;
          end
        end else if (sm_r[ax_r] != 0) begin
          if ({1'b0, d_r} < sps2) begin
            div_start = 1'b1; div_num = mul_p; div_den = {32'd0, sps_r};
            state_nxt = S_WAIT_V;
          end else if (sps_r != 0) begin
            div_start = 1'b1; div_num = {31'd0, d_r, 1'b0} + {32'd0, sps_r};
            div_den = {31'd0, sps2}; state_nxt = S_WAIT_SC;
          end
        end
      end
      S_WAIT_V: if (dctl.done) state_nxt = S_TEN;
      S_WAIT_SC: if (dctl.done) begin
        div_start = 1'b1;
        div_num = v_r[31] ? 64'(-64'(v_r)) : 64'(v_r);
        div_den = (div_q == 0) ? 64'd1 : div_q;
        state_nxt = S_WAIT_SM;
      end
      S_WAIT_SM: if (dctl.done) state_nxt = S_TEN;
      // Hold here while an earlier result still waits to be taken.
      S_TEN: if (!ov_r || !out_stall) state_nxt = S_NEXT;
      S_NEXT: state_nxt = ax_r ? S_OUT : S_AX;
      S_OUT: if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; en_r <= 1'b0; ov_r <= 1'b0; lfs_r <= '0;
      for (int k = 0; k < 2; k++) begin
        acc_r[k] <= '0; stt_r[k] <= STT_RST; cnt_r[k] <= 32'd1;
        sm_r[k] <= '0; zd_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && paddr == REG_SMOOTH_EN) en_r <= pwdata[0];
      if (state_r == S_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_acc) begin
          rel_r[0] <= in_rel_x; rel_r[1] <= in_rel_y;
          d_r <= 32'(({48'd0, in_frame_delta} << FRAC_BITS) >> 16);
          fn_r <= in_frame_number; ax_r <= 1'b0;
          v_r <= sat32(66'(acc_r[0]) <<< FRAC_BITS);
        end
        S_MOT: begin
          for (int k = 0; k < 2; k++) begin
            acc_r[k] <= sat32(66'(acc_r[k]) + 66'(rel_r[k]));
            cnt_r[k] <= usat_add(cnt_r[k],
              32'(rel_r[k][15] ? -17'(rel_r[k]) : 17'(rel_r[k])));
            if (lfs_r != fn_r && rel_r[k] != 0 && sm_r[k] != 0)
              stt_r[k] <= usat_add(stt_r[k], d_r);
          end
          lfs_r <= fn_r;
        end
        S_AX: if (en_r && d_r >= QUARTER) begin
          sm_r[ax_r] <= '0; zd_r[ax_r] <= '0;
        end
        S_SPS: if (dctl.done) sps_r <= div_q[31:0];
        S_DEC: begin
          vneg_r <= sval[31];
          if (v_r == 0) begin
            zd_r[ax_r] <= zd_sum[31:0];
            if (!(zd_sum[31:0] < sps_r)) sm_r[ax_r] <= '0;
          end else begin
            zd_r[ax_r] <= '0;
            if (sm_r[ax_r] == 0) sm_r[ax_r] <= v_r;
            else if (!({1'b0, d_r} < sps2) && sps_r == 0) sm_r[ax_r] <= '0;
          end
          dk_r <= (sm_r[ax_r] != 0 && v_r != 0) ? D_SM : D_V;
        end
        S_WAIT_V: if (dctl.done) begin
          v_r <= sat32(sq);
          if (dk_r == D_SM) sm_r[ax_r] <= sat32(sq);
        end
        S_WAIT_SC: if (dctl.done) vneg_r <= v_r[31];
        S_WAIT_SM: if (dctl.done) sm_r[ax_r] <= sat32(sq);
        S_TEN: if (!ov_r || !out_stall)
          res_r[ax_r] <= v_r[31] ? ten_q : 32'd0 - ten_q;
        S_NEXT: begin
          acc_r[ax_r] <= '0; ax_r <= 1'b1;
          v_r <= sat32(66'(acc_r[1]) <<< FRAC_BITS);
        end
        default: ;
      endcase
    end
  end

  // Result only appears after a frame-end sequence.
  a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == S_OUT) else $error("unexpected result");
  // Never accept while busy.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accept while busy");
  // Divider started only when idle.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !dctl.busy || dctl.done) else $error("divider overlap");
endmodule
